// ----- src/gvs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvs_pkg
// Shared types, widths and tables for the gradient value shader.
// ----------------------------------------------------------------------------
package gvs_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int CORDIC_STAGES = 16;

  localparam int PW   = 24;              // pixel coordinate width
  localparam int DW   = PW + 1;          // offset from centre
  localparam int UW   = FRAC_BITS + 28;  // rotated, scaled coordinate
  localparam int GW   = UW + 2;          // shape value
  localparam int HW   = (UW + 1) / 2;    // low half of a multiplier operand
  localparam int HHW  = UW - HW;         // high half
  localparam int MW   = 2 * UW;          // full product
  localparam int NW   = MW + 1;          // sum of two products
  localparam int RW   = NW + (NW % 2);   // radicand, even
  localparam int SQ   = RW / 2;          // root bits, one per stage
  localparam int REMW = SQ + 2;
  localparam int CORW = DW + 16 + 3;     // CORDIC x/y
  localparam int ZW   = 34;              // CORDIC angle, Q0.32 turns
  localparam int ATAN_ENTRIES = 24;

  typedef enum logic [2:0] {
    SHAPE_LINEAR, SHAPE_CIRCLE, SHAPE_MINXY, SHAPE_MAXXY,
    SHAPE_DIAMOND, SHAPE_SQRTXY, SHAPE_CONIC, SHAPE_ZERO
  } shape_t;

  typedef enum logic [2:0] {
    REG_ORG_X, REG_ORG_Y, REG_INV_RADIUS, REG_ROT_COS,
    REG_ROT_SIN, REG_START_TURNS, REG_SHAPE_MODE
  } reg_idx_t;

  typedef struct packed {
    logic signed [23:0] org_x;
    logic signed [23:0] org_y;
    logic        [23:0] inv_radius;
    logic signed [17:0] rot_cos;
    logic signed [17:0] rot_sin;
    logic signed [17:0] start_turns;
    shape_t             shape;
  } cfg_t;

  typedef struct packed {
    logic signed [UW-1:0] u;
    logic signed [UW-1:0] v;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
  } item_t;

  // atan(2^-i) in Q0.32 turns
  function automatic logic [31:0] atan_turns(input int i);
    logic [31:0] r;
    case (i)
      0: r = 32'd536870912;   1: r = 32'd316933405;   2: r = 32'd167458907;
      3: r = 32'd85004756;    4: r = 32'd42667331;    5: r = 32'd21354465;
      6: r = 32'd10680350;    7: r = 32'd5340245;     8: r = 32'd2670163;
      9: r = 32'd1335086;     10: r = 32'd667544;     11: r = 32'd333772;
      12: r = 32'd166886;     13: r = 32'd83443;      14: r = 32'd41721;
      15: r = 32'd20860;      16: r = 32'd10430;      17: r = 32'd5215;
      18: r = 32'd2607;       19: r = 32'd1303;       20: r = 32'd651;
      21: r = 32'd325;        22: r = 32'd162;        23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- src/gradient_value_shader.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_value_shader
// Gradient value per pixel: linear, radial, min/max, diamond, sqrt and conic.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   carries one pixel coordinate per transaction (pos_x, pos_y).
//   out_*  returns one result per pixel, in order: raw_value (Q15.16,
//          saturated) and norm_value (triangle-wave fold of |value|, Q1.16).
//   cfg_*  writes one register per cycle with cfg_we; write only while idle.
// Throughput is one pixel per clock while out_tready is high; nothing links
// one pixel to the next. Each pixel passes offset, rotate and scale, then the
// two-entry queue, then the back end, whose length is set by the floor square
// root pipeline (one root bit per stage, FRAC_BITS + 29 stages). Reset clears
// all valid state and loads the register defaults (centre 0, inv_radius 655,
// angle 0, linear shape). When out_tready is low the back end holds; the queue
// then fills and, at full rate, in_tready drops from the next cycle.
// ----------------------------------------------------------------------------
module gradient_value_shader (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [23:0] pos_x, [47:24] pos_y
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [31:0] raw_value, [48:32] norm_value
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);
  import gvs_pkg::*;

  cfg_t               cfg_r;
  item_t              f_item, q_item;
  logic               f_valid, q_ready, q_valid, b_ready;
  logic signed [31:0] raw;
  logic        [16:0] norm;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.org_x       <= '0;
      cfg_r.org_y       <= '0;
      cfg_r.inv_radius  <= 24'd655;
      cfg_r.rot_cos     <= 18'sd65536;
      cfg_r.rot_sin     <= '0;
      cfg_r.start_turns <= '0;
      cfg_r.shape       <= SHAPE_LINEAR;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORG_X:       cfg_r.org_x       <= cfg_wdata;
        REG_ORG_Y:       cfg_r.org_y       <= cfg_wdata;
        REG_INV_RADIUS:  cfg_r.inv_radius  <= cfg_wdata;
        REG_ROT_COS:     cfg_r.rot_cos     <= cfg_wdata[17:0];
        REG_ROT_SIN:     cfg_r.rot_sin     <= cfg_wdata[17:0];
        REG_START_TURNS: cfg_r.start_turns <= cfg_wdata[17:0];
        REG_SHAPE_MODE:  cfg_r.shape       <= shape_t'(cfg_wdata[2:0]);
        default: ;
      endcase
    end
  end

  gvs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_pos_x   (in_tdata[23:0]),
    .in_pos_y   (in_tdata[47:24]),
    .item_valid (f_valid),
    .item_ready (q_ready),
    .item       (f_item)
  );

  gvs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (q_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (b_ready),
    .pop_item   (q_item)
  );

  gvs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (q_valid),
    .item_ready (b_ready),
    .item       (q_item),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_raw    (raw),
    .out_norm   (norm)
  );

  assign out_tdata = {7'b0, norm, raw};

endmodule

// ----- src/gvs_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvs_front
// Offset, rotation and radius scaling of each pixel coordinate, five stages.
// ----------------------------------------------------------------------------
module gvs_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gvs_pkg::cfg_t        cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [23:0]   in_pos_x,
  input  logic signed [23:0]   in_pos_y,
  output logic                 item_valid,
  input  logic                 item_ready,
  output gvs_pkg::item_t       item
);
  import gvs_pkg::*;

  localparam int NST = 5;

  logic [NST-1:0]       vld_r;
  logic                 adv;
  logic signed [DW-1:0] dx_r [NST];
  logic signed [DW-1:0] dy_r [NST];
  logic signed [DW-1:0] dx_nxt, dy_nxt;
  logic signed [42:0]   pxc_r, pys_r, pyc_r, pxs_r;
  logic signed [43:0]   u24, v24;
  logic signed [35:0]   us_r, vs_r;
  logic signed [42:0]   uh_r, vh_r;
  logic        [41:0]   ul_r, vl_r;
  logic signed [60:0]   uf, vf;
  logic signed [UW-1:0] u_r, v_r;

  assign adv      = !vld_r[NST-1] || item_ready;
  assign in_ready = adv;

  assign dx_nxt = DW'(in_pos_x) - DW'(cfg.org_x);
  assign dy_nxt = DW'(in_pos_y) - DW'(cfg.org_y);
  assign u24    = 44'(pxc_r) + 44'(pys_r);
  assign v24    = 44'(pyc_r) - 44'(pxs_r);
  assign uf     = $signed({uh_r, 18'b0}) + $signed({19'b0, ul_r});
  assign vf     = $signed({vh_r, 18'b0}) + $signed({19'b0, vl_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r[0] <= dx_nxt;
      dy_r[0] <= dy_nxt;
      for (int k = 1; k < NST; k++) begin
        dx_r[k] <= dx_r[k-1];
        dy_r[k] <= dy_r[k-1];
      end
      pxc_r <= dx_r[0] * cfg.rot_cos;
      pys_r <= dy_r[0] * cfg.rot_sin;
      pyc_r <= dy_r[0] * cfg.rot_cos;
      pxs_r <= dx_r[0] * cfg.rot_sin;
      us_r  <= u24[43:8];
      vs_r  <= v24[43:8];
      // split the 36 bit operand so each product stays narrow
      uh_r  <= $signed(us_r[35:18]) * $signed({1'b0, cfg.inv_radius});
      vh_r  <= $signed(vs_r[35:18]) * $signed({1'b0, cfg.inv_radius});
      ul_r  <= us_r[17:0] * cfg.inv_radius;
      vl_r  <= vs_r[17:0] * cfg.inv_radius;
      u_r   <= uf[32-FRAC_BITS +: UW];
      v_r   <= vf[32-FRAC_BITS +: UW];
    end
  end

  assign item_valid = vld_r[NST-1];
  assign item.u     = u_r;
  assign item.v     = v_r;
  assign item.dx    = dx_r[NST-1];
  assign item.dy    = dy_r[NST-1];

endmodule

// ----- src/gvs_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvs_queue
// Two-entry queue between the coordinate front end and the shape back end.
// ----------------------------------------------------------------------------
module gvs_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  gvs_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output gvs_pkg::item_t pop_item
);
  import gvs_pkg::*;

  localparam logic [1:0] QDEPTH = 2'd2;

  item_t      mem_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign push_ready = cnt_r != QDEPTH;
  assign pop_valid  = cnt_r != 2'd0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= !wr_r;
      if (pop)  rd_r <= !rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_item;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
  a_push_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 2'd1) else $error("push lost");
  a_ptr_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == QDEPTH) |-> wr_r == rd_r)
    else $error("queue pointers disagree with count");
`endif

endmodule

// ----- src/gvs_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvs_back
// Shape evaluation: split multipliers, pipelined floor square root, CORDIC
// vectoring for conic, then saturation and triangle-wave normalisation.
// ----------------------------------------------------------------------------
module gvs_back (
  input  logic                clk,
  input  logic                rst_n,
  input  gvs_pkg::cfg_t       cfg,
  input  logic                item_valid,
  output logic                item_ready,
  input  gvs_pkg::item_t      item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_raw,
  output logic        [16:0]  out_norm
);
  import gvs_pkg::*;

  localparam int LAT    = 3 + SQ;
  localparam int CGL    = LAT - CORDIC_STAGES;
  localparam int SH_UP  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SH_DN  = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;
  localparam int RAW_UP = SH_DN;
  localparam int RAW_DN = SH_UP;
  localparam int RWW    = GW + 8;
  localparam int NMW    = FRAC_BITS + 18;
  localparam logic signed [RWW-1:0] RAW_MAX = RWW'(64'sd2147483647);
  localparam logic signed [RWW-1:0] RAW_MIN = ~RAW_MAX;
  localparam logic signed [ZW-1:0]  Z_QUARTER = ZW'(64'sd1073741824);

  logic                 adv;
  logic [LAT:0]         vld_r;

  // stage 0
  logic        [UW-1:0] au, av;
  logic signed [GW-1:0] gs_nxt;
  logic        [UW-1:0] ma_r, mb_r, mc_r, md_r;
  logic signed [GW-1:0] gs_r [LAT+1];

  // multiplier partials and sums
  logic [2*HW-1:0] pp_r [8];
  logic [MW-1:0]   p1_r, p2_r;

  // square root
  logic [RW-1:0]   rad_r  [SQ+1];
  logic [REMW-1:0] rem_r  [SQ+1];
  logic [SQ-1:0]   root_r [SQ+1];

  // CORDIC
  logic signed [CORW-1:0] cx_r [CORDIC_STAGES+1];
  logic signed [CORW-1:0] cy_r [CORDIC_STAGES+1];
  logic signed [ZW-1:0]   cz_r [CORDIC_STAGES+1];
  logic                   czero_r [CORDIC_STAGES+1];
  logic signed [CORW-1:0] x0, y0, xi, yi;
  logic signed [ZW-1:0]   zi;
  logic signed [GW-1:0]   ang, st_w, cg_nxt;
  logic signed [GW-1:0]   cg_r [CGL];

  // output
  logic signed [GW-1:0]    g;
  logic signed [RWW-1:0]   rw;
  logic        [GW-1:0]    mag;
  logic        [FRAC_BITS:0] m;
  logic signed [31:0]      raw_nxt;
  logic        [16:0]      norm_nxt;
  logic                    out_valid_r;
  logic signed [31:0]      out_raw_r;
  logic        [16:0]      out_norm_r;

  assign adv        = !out_valid_r || out_ready;
  assign item_ready = adv;

  // ---- stage 0: magnitudes, simple shapes, multiplier operands, CORDIC start
  assign au = item.u[UW-1] ? (~item.u + 1'b1) : item.u;
  assign av = item.v[UW-1] ? (~item.v + 1'b1) : item.v;

  always_comb begin
    case (cfg.shape)
      SHAPE_LINEAR:  gs_nxt = GW'(item.u);
      SHAPE_MINXY:   gs_nxt = (au < av) ? GW'(au) : GW'(av);
      SHAPE_MAXXY:   gs_nxt = (au > av) ? GW'(au) : GW'(av);
      SHAPE_DIAMOND: gs_nxt = GW'(au) + GW'(av);
      default:       gs_nxt = '0;
    endcase
  end

  always_comb begin
    x0 = CORW'(item.dy) <<< 16;
    y0 = CORW'(item.dx) <<< 16;
    xi = x0;
    yi = y0;
    zi = '0;
    // pre-rotate by a quarter turn into the right half plane
    if (x0 < 0) begin
      if (y0 >= 0) begin
        xi = y0;
        yi = -x0;
        zi = Z_QUARTER;
      end else begin
        xi = -y0;
        yi = x0;
        zi = -Z_QUARTER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ma_r       <= au;
      mb_r       <= (cfg.shape == SHAPE_SQRTXY) ? av : au;
      mc_r       <= (cfg.shape == SHAPE_SQRTXY) ? '0 : av;
      md_r       <= av;
      gs_r[0]    <= gs_nxt;
      cx_r[0]    <= xi;
      cy_r[0]    <= yi;
      cz_r[0]    <= zi;
      czero_r[0] <= (item.dx == '0) && (item.dy == '0);
      for (int k = 0; k < LAT; k++) gs_r[k+1] <= gs_r[k];
      for (int k = 1; k < CGL; k++) cg_r[k] <= cg_r[k-1];
      cg_r[0] <= cg_nxt;
    end
  end

  // ---- multiplier: four half-width partials per product
  always_ff @(posedge clk) begin
    if (adv) begin
      pp_r[0] <= (2*HW)'(ma_r[UW-1:HW]) * (2*HW)'(mb_r[UW-1:HW]);
      pp_r[1] <= (2*HW)'(ma_r[UW-1:HW]) * (2*HW)'(mb_r[HW-1:0]);
      pp_r[2] <= (2*HW)'(ma_r[HW-1:0]) * (2*HW)'(mb_r[UW-1:HW]);
      pp_r[3] <= (2*HW)'(ma_r[HW-1:0]) * (2*HW)'(mb_r[HW-1:0]);
      pp_r[4] <= (2*HW)'(mc_r[UW-1:HW]) * (2*HW)'(md_r[UW-1:HW]);
      pp_r[5] <= (2*HW)'(mc_r[UW-1:HW]) * (2*HW)'(md_r[HW-1:0]);
      pp_r[6] <= (2*HW)'(mc_r[HW-1:0]) * (2*HW)'(md_r[UW-1:HW]);
      pp_r[7] <= (2*HW)'(mc_r[HW-1:0]) * (2*HW)'(md_r[HW-1:0]);
      p1_r <= (MW'(pp_r[0]) << (2*HW)) + (MW'(pp_r[1]) << HW)
            + (MW'(pp_r[2]) << HW) + MW'(pp_r[3]);
      p2_r <= (MW'(pp_r[4]) << (2*HW)) + (MW'(pp_r[5]) << HW)
            + (MW'(pp_r[6]) << HW) + MW'(pp_r[7]);
      rad_r[0]  <= RW'(NW'(p1_r) + NW'(p2_r));
      rem_r[0]  <= '0;
      root_r[0] <= '0;
    end
  end

  // ---- floor square root, one root bit per stage
  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    logic [REMW+1:0] rem2, trial;
    logic            take;
    always_comb begin
      rem2  = {rem_r[k], rad_r[k][RW-1 -: 2]};
      trial = {2'b00, root_r[k], 2'b01};
      take  = rem2 >= trial;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rad_r[k+1]  <= rad_r[k] << 2;
        rem_r[k+1]  <= take ? REMW'(rem2 - trial) : REMW'(rem2);
        root_r[k+1] <= {root_r[k][SQ-2:0], take};
      end
    end
  end

  // ---- CORDIC vectoring, angle in Q0.32 turns
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    logic signed [CORW-1:0] xs, ys;
    logic signed [ZW-1:0]   at;
    always_comb begin
      xs = cx_r[i] >>> i;
      ys = cy_r[i] >>> i;
      at = (i < ATAN_ENTRIES) ? ZW'(atan_turns(i)) : '0;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        czero_r[i+1] <= czero_r[i];
        if (!cy_r[i][CORW-1]) begin
          cx_r[i+1] <= cx_r[i] + ys;
          cy_r[i+1] <= cy_r[i] - xs;
          cz_r[i+1] <= cz_r[i] + at;
        end else begin
          cx_r[i+1] <= cx_r[i] - ys;
          cy_r[i+1] <= cy_r[i] + xs;
          cz_r[i+1] <= cz_r[i] - at;
        end
      end
    end
  end

  always_comb begin
    ang  = czero_r[CORDIC_STAGES] ? '0 :
           GW'(cz_r[CORDIC_STAGES] >>> (32 - FRAC_BITS));
    st_w = (GW'(cfg.start_turns) <<< SH_UP) >>> SH_DN;
    // wrap by one turn when below the start angle
    if (ang < st_w) ang = ang + (GW'(1) <<< FRAC_BITS);
    cg_nxt = ang - st_w;
  end

  // ---- select, saturate, fold
  always_comb begin
    case (cfg.shape)
      SHAPE_CIRCLE, SHAPE_SQRTXY: g = GW'(root_r[SQ]);
      SHAPE_CONIC:                g = cg_r[CGL-1];
      default:                    g = gs_r[LAT];
    endcase
    rw = (RWW'(g) <<< RAW_UP) >>> RAW_DN;
    if (rw > RAW_MAX) begin
      raw_nxt = 32'sh7fffffff;
    end else if (rw < RAW_MIN) begin
      raw_nxt = 32'sh80000000;
    end else begin
      raw_nxt = rw[31:0];
    end
    mag = g[GW-1] ? (~g + 1'b1) : g;
    m   = mag[FRAC_BITS:0];
    if (m > ((FRAC_BITS+1)'(1) << FRAC_BITS)) begin
      m = (FRAC_BITS+1)'((FRAC_BITS+2)'(1) << (FRAC_BITS + 1)) - m;
    end
    norm_nxt = 17'((NMW'(m) << SH_DN) >> SH_UP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[LAT-1:0], item_valid};
      out_valid_r <= vld_r[LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_raw_r  <= raw_nxt;
      out_norm_r <= norm_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_raw   = out_raw_r;
  assign out_norm  = out_norm_r;

endmodule
